// ===== design/pic_style_eight_bit_alu_assert.svh =====
// ----------------------------------------------------------------------------
// pic_style_eight_bit_alu_assert.svh
// Assertion macros shared by the checker of the PIC-style ALU.
// ----------------------------------------------------------------------------
`ifndef PIC_STYLE_EIGHT_BIT_ALU_ASSERT_SVH
`define PIC_STYLE_EIGHT_BIT_ALU_ASSERT_SVH

// Clocked assertion, masked while reset is held.
`define PSA_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pic8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// pic8alu_pkg
// Types and opcode constants of the PIC-style eight-bit ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pic8alu_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_BIT  = 2'd1,
        KIND_PASS = 2'd2,
        KIND_LIT  = 2'd3
    } t_kind;

    // byte-oriented opcodes
    localparam logic [3:0] BOP_PASS_B  = 4'b0000;
    localparam logic [3:0] BOP_CLR     = 4'b0001;
    localparam logic [3:0] BOP_SUB     = 4'b0010;
    localparam logic [3:0] BOP_DEC     = 4'b0011;
    localparam logic [3:0] BOP_IOR     = 4'b0100;
    localparam logic [3:0] BOP_AND     = 4'b0101;
    localparam logic [3:0] BOP_XOR     = 4'b0110;
    localparam logic [3:0] BOP_ADD     = 4'b0111;
    localparam logic [3:0] BOP_PASS_A  = 4'b1000;
    localparam logic [3:0] BOP_COM     = 4'b1001;
    localparam logic [3:0] BOP_INC     = 4'b1010;
    localparam logic [3:0] BOP_DEC_ALT = 4'b1011;
    localparam logic [3:0] BOP_RRC     = 4'b1100;
    localparam logic [3:0] BOP_RLC     = 4'b1101;
    localparam logic [3:0] BOP_SWAP    = 4'b1110;
    localparam logic [3:0] BOP_INC_ALT = 4'b1111;

    // bit-oriented opcodes, upper two opcode bits
    localparam logic [1:0] XOP_CLR_BIT = 2'b00;
    localparam logic [1:0] XOP_SET_BIT = 2'b01;

    // literal opcodes
    localparam logic [3:0] LOP_PASS_A     = 4'b0000;
    localparam logic [3:0] LOP_PASS_A_ALT = 4'b0100;
    localparam logic [3:0] LOP_IOR        = 4'b1000;
    localparam logic [3:0] LOP_AND        = 4'b1001;
    localparam logic [3:0] LOP_XOR        = 4'b1010;
    localparam logic [3:0] LOP_SUB        = 4'b1100;
    localparam logic [3:0] LOP_SUB_ALT    = 4'b1101;
    localparam logic [3:0] LOP_ADD        = 4'b1110;
    localparam logic [3:0] LOP_ADD_ALT    = 4'b1111;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] operation;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic       carry_in;
        logic [2:0] bit_index;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] result;
        logic       carry_out;
    } t_alu_rsp;

endpackage

// ===== design/pic_style_eight_bit_alu.sv =====
// ----------------------------------------------------------------------------
// pic_style_eight_bit_alu
// PIC16-style eight-bit ALU with valid/ready channels, one beat per cycle while the receiver takes results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one instruction per beat: class,
//   opcode, two operands, carry flag and bit index. Output channel
//   o_valid/i_ready returns one beat per instruction: result and carry_out.
//   An accepted beat passes the input register, then the decode/add logic,
//   then the result register, which raises o_valid; while the result
//   register is stalled, the next beat waits in the input register.
//   Throughput is one beat per cycle: both registers reload at every edge
//   while the receiver keeps taking results.
//   When the receiver stalls, the result register holds its beat and the
//   input register can still take one more beat, so o_ready drops only
//   once both stages are full. o_ready depends on i_ready combinationally.
//   Synchronous active-low reset empties both stages and produces no beat.
//   No configuration, no state kept between beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pic_style_eight_bit_alu #(
    parameter int ALU_WIDTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_operation,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic [2:0] i_bit_index,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_result,
    output logic       o_carry_out
);
    import pic8alu_pkg::*;

    // stage 1: captured instruction
    logic     r_s1_valid;
    logic     n_s1_valid;
    t_alu_req r_s1_req;

    // stage 2: result register
    logic     r_s2_valid;
    logic     n_s2_valid;
    t_alu_rsp r_s2_rsp;

    t_alu_rsp core_rsp;
    logic     s2_load;
    logic     in_beat;

    // result slot is free when empty or being drained this cycle
    assign s2_load = !r_s2_valid || i_ready;
    assign o_ready = !r_s1_valid || s2_load;
    assign in_beat = i_valid && o_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s2_valid = r_s2_valid;
        if (s2_load) begin
            n_s2_valid = r_s1_valid;
            n_s1_valid = 1'b0;
        end
        if (in_beat) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_req.kind      <= t_kind'(i_kind);
            r_s1_req.operation <= i_operation;
            r_s1_req.operand_a <= i_operand_a;
            r_s1_req.operand_b <= i_operand_b;
            r_s1_req.carry_in  <= i_carry_in;
            r_s1_req.bit_index <= i_bit_index;
        end
        if (s2_load && r_s1_valid) begin
            r_s2_rsp <= core_rsp;
        end
    end

    pic8alu_core #(
        .ALU_WIDTH(ALU_WIDTH)
    ) u_core (
        .i_req(r_s1_req),
        .o_rsp(core_rsp)
    );

    assign o_valid     = r_s2_valid;
    assign o_result    = r_s2_rsp.result;
    assign o_carry_out = r_s2_rsp.carry_out;

endmodule

// ===== design/pic8alu_core.sv =====
// ----------------------------------------------------------------------------
// pic8alu_core
// Combinational datapath: decodes one instruction and forms result and carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pic8alu_core #(
    parameter int ALU_WIDTH = 8
) (
    input  pic8alu_pkg::t_alu_req i_req,
    output pic8alu_pkg::t_alu_rsp o_rsp
);
    import pic8alu_pkg::*;

    localparam int W = ALU_WIDTH;

    logic [W:0]   a_x;
    logic [W:0]   b_x;
    logic [W:0]   sum_ab;
    logic [W:0]   dif_ab;
    logic [W:0]   inc_a;
    logic [W:0]   dec_a;
    logic [W-1:0] rot_r;
    logic [W-1:0] rot_l;
    logic [7:0]   bit_mask;
    logic [7:0]   a;
    logic [7:0]   b;

    assign a   = i_req.operand_a;
    assign b   = i_req.operand_b;
    assign a_x = {{(W + 1 - 8){1'b0}}, a};
    assign b_x = {{(W + 1 - 8){1'b0}}, b};

    assign sum_ab = a_x + b_x;
    assign dif_ab = a_x - b_x;
    assign inc_a  = a_x + {{W{1'b0}}, 1'b1};
    assign dec_a  = a_x - {{W{1'b0}}, 1'b1};

    // rotates act on the full working width; only the low byte leaves
    assign rot_r = {i_req.carry_in, a_x[W-1:1]};
    assign rot_l = {a_x[W-2:0], i_req.carry_in};

    assign bit_mask = 8'd1 << i_req.bit_index;

    always_comb begin
        o_rsp.result    = b;
        o_rsp.carry_out = 1'b0;
        unique case (i_req.kind)
            KIND_BYTE: begin
                unique case (i_req.operation)
                    BOP_PASS_B: o_rsp.result = b;
                    BOP_CLR:    o_rsp.result = 8'd0;
                    BOP_SUB: begin
                        o_rsp.result    = dif_ab[7:0];
                        o_rsp.carry_out = dif_ab[W];
                    end
                    BOP_DEC, BOP_DEC_ALT: begin
                        o_rsp.result    = dec_a[7:0];
                        o_rsp.carry_out = dec_a[W];
                    end
                    BOP_IOR:    o_rsp.result = a | b;
                    BOP_AND:    o_rsp.result = a & b;
                    BOP_XOR:    o_rsp.result = a ^ b;
                    BOP_ADD: begin
                        o_rsp.result    = sum_ab[7:0];
                        o_rsp.carry_out = sum_ab[W];
                    end
                    BOP_PASS_A: o_rsp.result = a;
                    BOP_COM:    o_rsp.result = ~a;
                    BOP_INC, BOP_INC_ALT: begin
                        o_rsp.result    = inc_a[7:0];
                        o_rsp.carry_out = inc_a[W];
                    end
                    BOP_RRC: begin
                        o_rsp.result    = rot_r[7:0];
                        o_rsp.carry_out = a[0];
                    end
                    BOP_RLC: begin
                        o_rsp.result    = rot_l[7:0];
                        o_rsp.carry_out = a_x[W-1];
                    end
                    default:    o_rsp.result = {a[3:0], a[7:4]}; // nibble swap
                endcase
            end
            KIND_BIT: begin
                unique case (i_req.operation[3:2])
                    XOP_CLR_BIT: o_rsp.result = a & ~bit_mask;
                    XOP_SET_BIT: o_rsp.result = a | bit_mask;
                    default:     o_rsp.result = a & bit_mask; // test
                endcase
            end
            KIND_LIT: begin
                unique case (i_req.operation)
                    LOP_ADD, LOP_ADD_ALT: begin
                        o_rsp.result    = sum_ab[7:0];
                        o_rsp.carry_out = sum_ab[W];
                    end
                    LOP_SUB, LOP_SUB_ALT: begin
                        o_rsp.result    = dif_ab[7:0];
                        o_rsp.carry_out = dif_ab[W];
                    end
                    LOP_AND:                o_rsp.result = a & b;
                    LOP_IOR:                o_rsp.result = a | b;
                    LOP_XOR:                o_rsp.result = a ^ b;
                    LOP_PASS_A, LOP_PASS_A_ALT: o_rsp.result = a;
                    default:                o_rsp.result = b;
                endcase
            end
            default: o_rsp.result = b; // pass class
        endcase
    end

endmodule

// ===== design/pic8alu_checker.sv =====
// ----------------------------------------------------------------------------
// pic8alu_checker
// Port-level checks of the PIC-style ALU, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pic_style_eight_bit_alu_assert.svh"

module pic8alu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_result,
    input logic       o_carry_out
);

    // stalled result beat stays offered, payload held
    `PSA_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_result) && $stable(o_carry_out)), "stalled result beat changed")

    // with the result register empty the input side must take a beat
    `PSA_ASSERT_RUN(a_ready_when_empty, i_clk, i_rst_n, !o_valid |-> o_ready, "o_ready low with empty output")

    // a result appears only after an input beat has passed the input and result registers
    `PSA_ASSERT_RUN(a_no_invented, i_clk, i_rst_n, $rose(o_valid) |-> $past(i_valid && o_ready, 2), "result without input beat")

    // reset empties the output stage
    `PSA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "o_valid high after reset")

endmodule

bind pic_style_eight_bit_alu pic8alu_checker u_checker (.*);

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PIC-style eight-bit ALU. A directed set of
// instructions covers every byte opcode, each bit and literal operation
// and the operand extremes. Random streams then run with the sender and
// the receiver idling in different ways. Each accepted beat is predicted
// in the bench and compared with the returned beat, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import pic8alu_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------------
    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_kind;
    logic [3:0] i_operation;
    logic [7:0] i_operand_a;
    logic [7:0] i_operand_b;
    logic       i_carry_in;
    logic [2:0] i_bit_index;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_result;
    logic       o_carry_out;

    // Pending results, oldest first, and the running error count.
    t_alu_rsp   pending_results[$];
    int         error_count;

    // Idling controls. A maximum of zero switches that kind of idling off.
    int         send_gap_max;
    int         send_burst_left;
    int         stall_max;
    int         stall_left;
    int         run_left;

    pic_style_eight_bit_alu i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_operation (i_operation),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_carry_in  (i_carry_in),
        .i_bit_index (i_bit_index),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .o_carry_out (o_carry_out)
    );

    // 2 ns period; all inputs known from time zero.
    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_kind      = KIND_PASS;
        i_operation = BOP_PASS_B;
        i_operand_a = 8'h00;
        i_operand_b = 8'h00;
        i_carry_in  = 1'b0;
        i_bit_index = 3'd0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Expected ALU outcome of one instruction. Arithmetic is done nine bits
    // wide; bit 8 is the carry, so subtract and decrement give 1 on borrow.
    // ------------------------------------------------------------------------
    function automatic t_alu_rsp alu_outcome(input logic [1:0] kind,
                                             input logic [3:0] op,
                                             input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic       cin,
                                             input logic [2:0] idx);
        t_alu_rsp   rsp;
        logic [8:0] wide;
        logic [7:0] mask;
        rsp.result    = b;
        rsp.carry_out = 1'b0;
        mask          = 8'd1 << idx;
        case (t_kind'(kind))
            KIND_BYTE: begin
                case (op)
                    BOP_PASS_B: rsp.result = b;
                    BOP_CLR:    rsp.result = 8'h00;
                    BOP_SUB: begin
                        wide = {1'b0, a} - {1'b0, b};
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    BOP_DEC, BOP_DEC_ALT: begin
                        wide = {1'b0, a} - 9'd1;
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    BOP_IOR:    rsp.result = a | b;
                    BOP_AND:    rsp.result = a & b;
                    BOP_XOR:    rsp.result = a ^ b;
                    BOP_ADD: begin
                        wide = {1'b0, a} + {1'b0, b};
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    BOP_PASS_A: rsp.result = a;
                    BOP_COM:    rsp.result = ~a;
                    BOP_INC, BOP_INC_ALT: begin
                        wide = {1'b0, a} + 9'd1;
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    // rotates go through carry: old edge bit out, carry in
                    BOP_RRC: begin
                        rsp.carry_out = a[0];
                        rsp.result    = {cin, a[7:1]};
                    end
                    BOP_RLC: begin
                        rsp.carry_out = a[7];
                        rsp.result    = {a[6:0], cin};
                    end
                    default:    rsp.result = {a[3:0], a[7:4]};
                endcase
            end
            KIND_BIT: begin
                // only the upper two opcode bits select the bit operation
                case (op[3:2])
                    XOP_CLR_BIT: rsp.result = a & ~mask;
                    XOP_SET_BIT: rsp.result = a | mask;
                    default:     rsp.result = a & mask;
                endcase
            end
            KIND_LIT: begin
                case (op)
                    LOP_ADD, LOP_ADD_ALT: begin
                        wide = {1'b0, a} + {1'b0, b};
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    LOP_SUB, LOP_SUB_ALT: begin
                        wide = {1'b0, a} - {1'b0, b};
                        {rsp.carry_out, rsp.result} = wide;
                    end
                    LOP_AND:                rsp.result = a & b;
                    LOP_IOR:                rsp.result = a | b;
                    LOP_XOR:                rsp.result = a ^ b;
                    LOP_PASS_A, LOP_PASS_A_ALT: rsp.result = a;
                    default:                rsp.result = b;
                endcase
            end
            default: rsp.result = b;
        endcase
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: drives one instruction beat at the falling edge and holds it
    // until accepted. Between bursts it drops valid for a random gap. Valid
    // is left high after acceptance so back-to-back beats need no toggle.
    // ------------------------------------------------------------------------
    task automatic send_instruction(input logic [1:0] kind,
                                    input logic [3:0] op,
                                    input logic [7:0] a,
                                    input logic [7:0] b,
                                    input logic       cin,
                                    input logic [2:0] idx);
        if (send_gap_max > 0 && send_burst_left == 0) begin
            repeat ($urandom_range(1, send_gap_max)) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            send_burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        i_carry_in  <= cin;
        i_bit_index <= idx;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(alu_outcome(kind, op, a, b, cin, idx));
        if (send_burst_left > 0)
            send_burst_left--;
    endtask

    // Pull valid low at the next falling edge, once the stimulus is done.
    task automatic idle_sender();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: alternating runs of ready and stalls of random length, on
    // its own schedule, independent of the sender.
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_max == 0) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (run_left > 0) begin
                i_ready <= 1'b1;
                run_left--;
            end else begin
                // start a fresh run/stall pair; this cycle is a stall
                i_ready    <= 1'b0;
                run_left   = $urandom_range(0, 12);
                stall_left = $urandom_range(0, stall_max - 1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every returned beat is matched with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_alu_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: result=%02h carry_out=%0b",
                       o_result, o_carry_out);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result !== want.result) begin
                    $error("result: expected %02h, got %02h", want.result, o_result);
                    error_count++;
                end
                if (o_carry_out !== want.carry_out) begin
                    $error("carry_out: expected %0b, got %0b",
                           want.carry_out, o_carry_out);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Every byte opcode, with operands at the carry and borrow edges.
    task automatic test_byte_ops();
        send_instruction(KIND_BYTE, BOP_PASS_B,  8'h00, 8'hFF, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_CLR,     8'hFF, 8'hFF, 1'b1, 3'd7);
        send_instruction(KIND_BYTE, BOP_SUB,     8'h00, 8'h01, 1'b0, 3'd0); // borrow
        send_instruction(KIND_BYTE, BOP_DEC,     8'h00, 8'h00, 1'b0, 3'd0); // wraps
        send_instruction(KIND_BYTE, BOP_IOR,     8'hA5, 8'h5A, 1'b0, 3'd0);
        send_instruction(KIND_BYTE, BOP_AND,     8'hFF, 8'h0F, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_XOR,     8'hFF, 8'hFF, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_ADD,     8'hFF, 8'hFF, 1'b0, 3'd0); // carry
        send_instruction(KIND_BYTE, BOP_PASS_A,  8'h80, 8'h00, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_COM,     8'h00, 8'hFF, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_INC,     8'hFF, 8'h00, 1'b0, 3'd0); // carry
        send_instruction(KIND_BYTE, BOP_DEC_ALT, 8'h01, 8'hFF, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_RRC,     8'h01, 8'h00, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_RLC,     8'h80, 8'h00, 1'b0, 3'd0);
        send_instruction(KIND_BYTE, BOP_SWAP,    8'hC3, 8'h00, 1'b1, 3'd0);
        send_instruction(KIND_BYTE, BOP_INC_ALT, 8'h7F, 8'h00, 1'b0, 3'd0);
    endtask

    // Clear, set and test; the low opcode bits are don't-care here.
    task automatic test_bit_ops();
        send_instruction(KIND_BIT, {XOP_CLR_BIT, 2'b11}, 8'hFF, 8'h00, 1'b1, 3'd0);
        send_instruction(KIND_BIT, {XOP_SET_BIT, 2'b10}, 8'h00, 8'hFF, 1'b0, 3'd7);
        send_instruction(KIND_BIT, 4'b1001,              8'hFF, 8'h00, 1'b0, 3'd4);
    endtask

    // Literal opcodes, an unlisted literal opcode, and the pass class.
    task automatic test_literal_and_pass();
        send_instruction(KIND_LIT,  LOP_ADD,    8'hFF, 8'h01, 1'b0, 3'd0);
        send_instruction(KIND_LIT,  LOP_SUB,    8'h00, 8'hFF, 1'b1, 3'd0);
        send_instruction(KIND_LIT,  LOP_AND,    8'hF0, 8'h3C, 1'b0, 3'd0);
        send_instruction(KIND_LIT,  LOP_IOR,    8'hF0, 8'h0F, 1'b0, 3'd0);
        send_instruction(KIND_LIT,  LOP_XOR,    8'hAA, 8'hFF, 1'b0, 3'd0);
        send_instruction(KIND_LIT,  LOP_PASS_A, 8'h5A, 8'hA5, 1'b1, 3'd0);
        send_instruction(KIND_LIT,  4'b0111,    8'h12, 8'h34, 1'b1, 3'd0);
        send_instruction(KIND_PASS, BOP_ADD,    8'hFF, 8'h80, 1'b1, 3'd5);
    endtask

    // ------------------------------------------------------------------------
    // Random stream: every field uniform, operands biased a little towards
    // the values where carries and borrows flip.
    // ------------------------------------------------------------------------
    task automatic test_random_stream(input int count, input int gap_max,
                                      input int stall_limit);
        logic [7:0] edge_vals [5];
        logic [7:0] a;
        logic [7:0] b;
        edge_vals = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F};
        send_gap_max    = gap_max;
        send_burst_left = 0;
        stall_max       = stall_limit;
        repeat (count) begin
            a = ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 4)]
                                            : 8'($urandom);
            b = ($urandom_range(0, 3) == 0) ? edge_vals[$urandom_range(0, 4)]
                                            : 8'($urandom);
            send_instruction(2'($urandom), 4'($urandom), a, b,
                             1'($urandom), 3'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain_cycles;
        error_count     = 0;
        send_gap_max    = 0;
        send_burst_left = 0;
        stall_max       = 0;
        stall_left      = 0;
        run_left        = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed set with a light receiver stall
        stall_max = 3;
        test_byte_ops();
        test_bit_ops();
        test_literal_and_pass();

        // random streams: no idling, bursty sender, heavy back-pressure,
        // then sparse sender with a mild stall
        test_random_stream(300, 0, 0);
        test_random_stream(350, 6, 4);
        test_random_stream(350, 2, 10);
        test_random_stream(300, 10, 2);
        idle_sender();

        // let the pipeline drain with the receiver always ready
        stall_max    = 0;
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < 1000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        // two-stage pipeline; an extra wait after the drain catches any stray beat
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result beat(s) never arrived", pending_results.size());
            error_count++;
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: the slowest correct run is well under 100 us.
    initial begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

endmodule
